// File: design/tsc_pkg.sv
package tsc_pkg;

  localparam int MaxRounds   = 512;
  localparam int KeyWords    = 2 * MaxRounds;
  localparam int KeyAddrW    = $clog2(KeyWords);
  localparam int RoundIdxW   = $clog2(MaxRounds);
  localparam int RoundCntW   = RoundIdxW + 1;
  localparam int InDataW     = 80;
  localparam int OutDataW    = 72;

  localparam logic [1:0] CmdEncrypt = 2'd0;
  localparam logic [1:0] CmdDecrypt = 2'd1;
  localparam logic [1:0] CmdLoad    = 2'd2;

  localparam logic CfgDomainHalf = 1'b0;
  localparam logic CfgRoundCount = 1'b1;

  localparam logic [63:0] HalfLimit = 64'h8000_0000_0000_0000;

  // keyed BLAKE2b parameter word: digest 16 bytes, key 16 bytes, fanout and depth 1
  localparam logic [63:0] ParamWord = 64'h0000_0000_0101_1010;
  localparam logic [63:0] KeyCount  = 64'd128;
  localparam logic [63:0] MsgCount  = 64'd136;

  localparam logic [63:0] Iv [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
    64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  typedef enum logic [2:0] {
    ST_IDLE, ST_KEY_LO, ST_KEY_HI, ST_KEY_CAP, ST_HASH, ST_DONE
  } tsc_state_t;

  typedef enum logic [1:0] {
    BL_IDLE, BL_RUN, BL_FOLD
  } tsc_blake_state_t;

  typedef struct packed {
    logic done;
    logic par;
  } tsc_hash_rsp_t;

  // message schedule: nibble k of a row is the word index for mix input k
  function automatic logic [3:0] sigma(input logic [3:0] rnd, input logic [3:0] sel);
    logic [63:0] row;
    unique case (rnd)
      4'd0, 4'd10: row = 64'hFEDCBA9876543210;
      4'd1, 4'd11: row = 64'h357B20C16DF984AE;
      4'd2:        row = 64'h491763EADF250C8B;
      4'd3:        row = 64'h8F04A562EBCD1397;
      4'd4:        row = 64'hD386CB1EFA427509;
      4'd5:        row = 64'h91EF57D438B0A6C2;
      4'd6:        row = 64'hB8293670A4DEF15C;
      4'd7:        row = 64'hA2684F05931CE7BD;
      4'd8:        row = 64'h5A417D2C803B9EF6;
      4'd9:        row = 64'h0DC3E9BF5167482A;
      default:     row = 64'hFEDCBA9876543210;
    endcase
    return row[{sel, 2'b00} +: 4];
  endfunction

endpackage

// File: design/tsc_ram.sv
module tsc_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem_r [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// File: design/tsc_blake.sv
module tsc_blake (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [63:0]            key_lo,
  input  logic [63:0]            key_hi,
  input  logic [63:0]            value,
  output tsc_pkg::tsc_hash_rsp_t rsp
);
  import tsc_pkg::*;

  tsc_blake_state_t st_r, st_nxt;
  logic [63:0] h_r [8];
  logic [63:0] v_r [16];
  logic [63:0] v_nxt [16];
  logic [63:0] hn [8];
  logic [63:0] w0_r, w1_r, val_r;
  logic [3:0]  rnd_r;
  logic [2:0]  gi_r;
  logic        hf_r, ph_r, done_r, par_r;
  logic        last_step;

  logic [1:0]  j, ob, oc, od;
  logic [3:0]  ia, ib, ic, id, msel;
  logic [63:0] xw, a1, d1, c1, b1;

  assign last_step = (rnd_r == 4'd11) && (gi_r == 3'd7) && hf_r;

  // index of the four working words for this mix
  always_comb begin
    j  = gi_r[1:0];
    ob = j + {1'b0, gi_r[2]};
    oc = j + {gi_r[2], 1'b0};
    od = j + {gi_r[2], gi_r[2]};
    ia = {2'b00, j};
    ib = {2'b01, ob};
    ic = {2'b10, oc};
    id = {2'b11, od};
    msel = sigma(rnd_r, {gi_r, hf_r});
    xw = (msel == 4'd0) ? w0_r : ((msel == 4'd1) ? w1_r : 64'd0);
  end

  // half a mix function per cycle
  always_comb begin
    a1 = v_r[ia] + v_r[ib] + xw;
    if (!hf_r) begin
      d1 = {(v_r[id] ^ a1)} >> 32 | {(v_r[id] ^ a1)} << 32;
    end else begin
      d1 = {(v_r[id] ^ a1)} >> 16 | {(v_r[id] ^ a1)} << 48;
    end
    c1 = v_r[ic] + d1;
    if (!hf_r) begin
      b1 = (v_r[ib] ^ c1) >> 24 | (v_r[ib] ^ c1) << 40;
    end else begin
      b1 = (v_r[ib] ^ c1) >> 63 | (v_r[ib] ^ c1) << 1;
    end
    for (int i = 0; i < 16; i++) begin
      v_nxt[i] = v_r[i];
    end
    v_nxt[ia] = a1;
    v_nxt[ib] = b1;
    v_nxt[ic] = c1;
    v_nxt[id] = d1;
    for (int i = 0; i < 8; i++) begin
      hn[i] = h_r[i] ^ v_r[i] ^ v_r[i + 8];
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BL_IDLE: if (start) st_nxt = BL_RUN;
      BL_RUN:  if (last_step) st_nxt = BL_FOLD;
      BL_FOLD: st_nxt = ph_r ? BL_IDLE : BL_RUN;
      default: st_nxt = BL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= BL_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == BL_FOLD) && ph_r;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      BL_IDLE: begin
        if (start) begin
          for (int i = 0; i < 8; i++) begin
            h_r[i]     <= (i == 0) ? (Iv[0] ^ ParamWord) : Iv[i];
            v_r[i]     <= (i == 0) ? (Iv[0] ^ ParamWord) : Iv[i];
            v_r[i + 8] <= (i == 4) ? (Iv[4] ^ KeyCount) : Iv[i];
          end
          w0_r  <= key_lo;
          w1_r  <= key_hi;
          val_r <= value;
          ph_r  <= 1'b0;
          rnd_r <= '0;
          gi_r  <= '0;
          hf_r  <= 1'b0;
        end
      end
      BL_RUN: begin
        for (int i = 0; i < 16; i++) begin
          v_r[i] <= v_nxt[i];
        end
        hf_r <= ~hf_r;
        if (hf_r) begin
          gi_r <= gi_r + 3'd1;
          if (gi_r == 3'd7) begin
            rnd_r <= rnd_r + 4'd1;
          end
        end
      end
      BL_FOLD: begin
        if (!ph_r) begin
          // chain into the final block: the value alone, padded with zeros
          for (int i = 0; i < 8; i++) begin
            h_r[i]     <= hn[i];
            v_r[i]     <= hn[i];
            v_r[i + 8] <= (i == 4) ? (Iv[4] ^ MsgCount) :
                          ((i == 6) ? ~Iv[6] : Iv[i]);
          end
          w0_r  <= val_r;
          w1_r  <= 64'd0;
          ph_r  <= 1'b1;
          rnd_r <= '0;
          gi_r  <= '0;
          hf_r  <= 1'b0;
        end else begin
          par_r <= ^(hn[0] ^ hn[1]);
        end
      end
      default: ;
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.par  = par_r;

  a_done_after_fold: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(st_r) == BL_FOLD) else $error("digest done without final fold");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != BL_IDLE) |-> !start) else $error("hash started while busy");
  a_step_counter: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BL_RUN) |-> rnd_r < 4'd12) else $error("mix round counter overran");

endmodule

// File: design/thorp_shuffle_cipher_unit.sv
// Thorp-shuffle format-preserving cipher over 0 .. 2*domain_half-1.
// Input channel in_*: one transfer is an encrypt, decrypt or key-word load
// command. Loads write the key memory and give no result; command 3 is dropped.
// Result channel out_*: one transfer per encrypt or decrypt, holding the value
// and an out-of-domain flag (value passed unchanged when flagged).
// cfg_*: write domain_half (index 0) or round_count (index 1) while idle.
// Throughput: one command at a time; in_tready is high only while idle.
// Each round reads two key words, runs two BLAKE2b compressions on one
// shared half-mix unit and then hands back the bit.
// Out-of-domain or zero-round items skip the rounds and go straight to the
// done state. A load writes the key memory on acceptance; the unit stays idle.
// Reset sets domain_half and round_count to 1 and empties the output stage;
// the key memory is not cleared and holds nothing valid until loaded.
// A stalled receiver holds the result in the output register; a new command
// is still accepted, and its own result waits until that transfer is taken.
module thorp_shuffle_cipher_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // command[1:0], data_value[65:2], key_word_index[75:66], zero pad
  input  logic [tsc_pkg::InDataW-1:0]   in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // result_value[63:0], out_of_domain[64], zero pad
  output logic [tsc_pkg::OutDataW-1:0]  out_tdata,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [63:0]                   cfg_wdata
);
  import tsc_pkg::*;

  tsc_state_t st_r, st_nxt;

  logic [63:0]          dh_r;
  logic [9:0]           rc_r;
  logic [63:0]          m_r, hh_r, m_nxt;
  logic [RoundCntW-1:0] n_r, cnt_r, krev;
  logic                 dec_r, ood_r;
  logic [63:0]          key_lo_r;
  logic                 out_tvalid_r;
  logic [OutDataW-1:0]  out_tdata_r;

  logic [1:0]           in_cmd;
  logic [63:0]          in_val;
  logic [KeyAddrW-1:0]  in_idx;
  logic                 acc, in_dom, out_load;
  logic [63:0]          hh_in;
  logic [RoundCntW-1:0] nn_in;
  logic [RoundIdxW-1:0] kr;
  logic [KeyAddrW-1:0]  raddr;
  logic [63:0]          rdata, rem;
  logic                 ge, last_round;
  tsc_hash_rsp_t        hrsp;

  assign in_cmd = in_tdata[1:0];
  assign in_val = in_tdata[65:2];
  assign in_idx = in_tdata[75:66];

  assign in_tready = (st_r == ST_IDLE);
  assign acc       = in_tvalid && in_tready;

  // clamp the domain and the round count, decide membership at acceptance
  always_comb begin
    hh_in  = dh_r[63] ? HalfLimit : dh_r;
    nn_in  = (rc_r > 10'(MaxRounds)) ? RoundCntW'(MaxRounds) : RoundCntW'(rc_r);
    if (dh_r == 64'd0) begin
      in_dom = 1'b0;
    end else if (dh_r[63]) begin
      in_dom = 1'b1;
    end else begin
      in_dom = in_val < {dh_r[62:0], 1'b0};
    end
  end

  // decrypt walks the round keys backwards
  assign krev  = n_r - RoundCntW'(1) - cnt_r;
  assign kr    = dec_r ? krev[RoundIdxW-1:0] : cnt_r[RoundIdxW-1:0];
  assign raddr = {kr, (st_r == ST_KEY_HI)};

  tsc_ram #(.Width(64), .Depth(KeyWords)) u_keys (
    .clk   (clk),
    .we    (acc && (in_cmd == CmdLoad)),
    .waddr (in_idx),
    .wdata (in_val),
    .raddr (raddr),
    .rdata (rdata)
  );

  // value is below 2H, so the encrypt split is one compare and subtract; decrypt halves the value
  always_comb begin
    ge = m_r >= hh_r;
    if (dec_r) begin
      rem = {1'b0, m_r[63:1]};
    end else begin
      rem = ge ? (m_r - hh_r) : m_r;
    end
    if (dec_r) begin
      m_nxt = rem + ((m_r[0] ^ hrsp.par) ? hh_r : 64'd0);
    end else begin
      m_nxt = {rem[62:0], ge ^ hrsp.par};
    end
  end

  tsc_blake u_blake (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (st_r == ST_KEY_CAP),
    .key_lo (key_lo_r),
    .key_hi (rdata),
    .value  (rem),
    .rsp    (hrsp)
  );

  assign last_round = (cnt_r + RoundCntW'(1)) == n_r;
  assign out_load   = (st_r == ST_DONE) && (!out_tvalid_r || out_tready);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (acc && ((in_cmd == CmdEncrypt) || (in_cmd == CmdDecrypt))) begin
          st_nxt = (in_dom && (nn_in != '0)) ? ST_KEY_LO : ST_DONE;
        end
      end
      ST_KEY_LO:  st_nxt = ST_KEY_HI;
      ST_KEY_HI:  st_nxt = ST_KEY_CAP;
      ST_KEY_CAP: st_nxt = ST_HASH;
      ST_HASH: begin
        if (hrsp.done) st_nxt = last_round ? ST_DONE : ST_KEY_LO;
      end
      ST_DONE: begin
        if (out_load) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      dh_r         <= 64'd1;
      rc_r         <= 10'd1;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CfgDomainHalf: dh_r <= cfg_wdata;
          CfgRoundCount: rc_r <= cfg_wdata[9:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // datapath: hold the message, advance it once per finished digest
  always_ff @(posedge clk) begin
    if (acc) begin
      m_r   <= in_val;
      hh_r  <= hh_in;
      n_r   <= nn_in;
      dec_r <= (in_cmd == CmdDecrypt);
      ood_r <= !in_dom;
      cnt_r <= '0;
    end
    if (st_r == ST_KEY_HI) begin
      key_lo_r <= rdata;
    end
    if ((st_r == ST_HASH) && hrsp.done) begin
      m_r   <= m_nxt;
      cnt_r <= cnt_r + RoundCntW'(1);
    end
    if (out_load) begin
      out_tdata_r <= {{(OutDataW - 65){1'b0}}, ood_r, m_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(st_r) == ST_DONE)
    else $error("result raised outside the done state");
  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_HASH) |-> cnt_r < n_r) else $error("round counter passed round count");
  a_digest_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
    hrsp.done |-> st_r == ST_HASH) else $error("digest arrived outside hash state");
  a_done_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE) && out_tvalid_r && !out_tready |=> st_r == ST_DONE)
    else $error("result overwritten while stalled");

endmodule
